@@ src/ilb_pkg.sv @@
// Package for the indexed list buffer: field widths, action and status codes,
// and the result beat structure shared by the controller and the top level.
// Depends on nothing.
`default_nettype none

package ilb_pkg;

  // Fixed widths of the channel fields.
  localparam int ACTION_W = 2;
  localparam int POS_W    = 8;
  localparam int VALUE_W  = 32;
  localparam int ELEM_W   = 32;
  localparam int COUNT_W  = 9;
  localparam int STATUS_W = 2;

  // Requested action of an input beat.
  typedef enum logic [ACTION_W-1:0] {
    ACT_APPEND = 2'd0,
    ACT_READ   = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  // Status reported with every result beat.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // One result beat.
  typedef struct packed {
    logic [ELEM_W-1:0]  element;
    logic [COUNT_W-1:0] count;
    logic               empty_res;
    status_t            status;
  } res_t;

endpackage

`default_nettype wire

@@ src/ilb_if.sv @@
// Channel interfaces of the indexed list buffer: the request channel and the
// result channel, each with valid, ready and payload. Depends on ilb_pkg.
`default_nettype none

interface ilb_in_if;
  logic                          valid;
  logic                          ready;
  logic [ilb_pkg::ACTION_W-1:0]  action;
  logic [ilb_pkg::POS_W-1:0]     position;
  logic [ilb_pkg::VALUE_W-1:0]   value;

  modport source (output valid, action, position, value, input ready);
  modport sink   (input valid, action, position, value, output ready);
endinterface

interface ilb_out_if;
  logic                          valid;
  logic                          ready;
  logic [ilb_pkg::ELEM_W-1:0]    element;
  logic [ilb_pkg::COUNT_W-1:0]   count;
  logic                          empty_res;
  logic [ilb_pkg::STATUS_W-1:0]  status;

  modport source (output valid, element, count, empty_res, status, input ready);
  modport sink   (input valid, element, count, empty_res, status, output ready);
endinterface

`default_nettype wire

@@ src/ilb_mem.sv @@
// Element store of the indexed list buffer: a simple dual-port synchronous
// RAM with one write port and one registered read port. No dependencies.
`default_nettype none

module ilb_mem #(
  parameter int DEPTH      = 256,
  parameter int DATA_WIDTH = 32,
  localparam int AW        = $clog2(DEPTH)
) (
  input  wire logic                  clk,
  input  wire logic                  wr_en,
  input  wire logic [AW-1:0]         wr_addr,
  input  wire logic [DATA_WIDTH-1:0] wr_data,
  input  wire logic                  rd_en,
  input  wire logic [AW-1:0]         rd_addr,
  output logic      [DATA_WIDTH-1:0] rd_data
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ src/ilb_ctrl.sv @@
// Sequencer of the indexed list buffer: decodes request beats, keeps the
// element count, drives the element RAM and moves later elements down on a
// remove. Depends on ilb_pkg and ilb_if.
`default_nettype none

module ilb_ctrl #(
  parameter int DEPTH      = 256,
  parameter int DATA_WIDTH = 32,
  localparam int AW        = $clog2(DEPTH)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  ilb_in_if.sink                     in_ch,
  output logic                       res_valid,
  output ilb_pkg::res_t              res,
  input  wire logic                  res_ready,
  output logic                       mem_wr_en,
  output logic [AW-1:0]              mem_wr_addr,
  output logic [DATA_WIDTH-1:0]      mem_wr_data,
  output logic                       mem_rd_en,
  output logic [AW-1:0]              mem_rd_addr,
  input  wire logic [DATA_WIDTH-1:0] mem_rd_data
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > ilb_pkg::POS_W) ? CW : ilb_pkg::POS_W;
  localparam int XW = (DATA_WIDTH > ilb_pkg::VALUE_W) ? DATA_WIDTH : ilb_pkg::VALUE_W;
  localparam int OW = (CW > ilb_pkg::COUNT_W) ? CW : ilb_pkg::COUNT_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD_WAIT,
    S_SHIFT,
    S_RESP
  } state_t;

  state_t              state_r;
  logic [CW-1:0]       count_r;
  logic [CW-1:0]       idx_r;
  logic                is_remove_r;
  logic [ilb_pkg::ELEM_W-1:0] res_elem_r;
  ilb_pkg::status_t    res_status_r;

  logic                fire;
  ilb_pkg::action_t    act;
  logic [PW-1:0]       pos_ext;
  logic                in_range;
  logic                full;
  logic [CW:0]         cnt_ext;
  logic [CW:0]         idx_p1;
  logic [CW:0]         idx_p2;
  logic [XW-1:0]       val_ext;
  logic [XW-1:0]       rd_ext;
  logic [OW-1:0]       cnt_out;

  // Request decode.
  assign in_ch.ready = (state_r == S_IDLE);
  assign fire        = in_ch.valid && in_ch.ready;
  assign act         = ilb_pkg::action_t'(in_ch.action);
  assign pos_ext     = PW'(in_ch.position);
  assign in_range    = (pos_ext < PW'(count_r));
  assign full        = (count_r == CW'(DEPTH));
  assign cnt_ext     = {1'b0, count_r};
  assign idx_p1      = {1'b0, idx_r} + (CW+1)'(1);
  assign idx_p2      = {1'b0, idx_r} + (CW+1)'(2);
  assign val_ext     = XW'(in_ch.value);
  assign rd_ext      = XW'(mem_rd_data);
  assign cnt_out     = OW'(count_r);

  // RAM write: an append at the tail, or one step of the move-down on remove.
  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = count_r[AW-1:0];
    mem_wr_data = val_ext[DATA_WIDTH-1:0];
    if (state_r == S_SHIFT) begin
      mem_wr_en   = 1'b1;
      mem_wr_addr = idx_r[AW-1:0];
      mem_wr_data = mem_rd_data;
    end else if (fire && act == ilb_pkg::ACT_APPEND && !full) begin
      mem_wr_en = 1'b1;
    end
  end

  // RAM read: the addressed element, then, on a remove, each later element in turn.
  always_comb begin
    mem_rd_en   = 1'b0;
    mem_rd_addr = pos_ext[AW-1:0];
    case (state_r)
      S_IDLE: begin
        mem_rd_en = fire && in_range &&
                    (act == ilb_pkg::ACT_READ || act == ilb_pkg::ACT_REMOVE);
      end
      S_RD_WAIT: begin
        mem_rd_addr = idx_p1[AW-1:0];
        mem_rd_en   = is_remove_r && (idx_p1 < cnt_ext);
      end
      S_SHIFT: begin
        mem_rd_addr = idx_p2[AW-1:0];
        mem_rd_en   = (idx_p2 < cnt_ext);
      end
      default: begin
        mem_rd_en = 1'b0;
      end
    endcase
  end

  // Sequencer state, element count and result fields.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (fire) begin
            idx_r        <= pos_ext[CW-1:0];
            is_remove_r  <= (act == ilb_pkg::ACT_REMOVE);
            res_elem_r   <= '0;
            res_status_r <= ilb_pkg::ST_OK;
            state_r      <= S_RESP;
            case (act)
              ilb_pkg::ACT_APPEND: begin
                if (full) begin
                  res_status_r <= ilb_pkg::ST_FULL;
                end else begin
                  count_r <= count_r + CW'(1);
                end
              end
              ilb_pkg::ACT_READ, ilb_pkg::ACT_REMOVE: begin
                if (in_range) begin
                  state_r <= S_RD_WAIT;
                end else begin
                  res_status_r <= ilb_pkg::ST_RANGE;
                end
              end
              default: begin
                res_status_r <= ilb_pkg::ST_OK;
              end
            endcase
          end
        end
        S_RD_WAIT: begin
          res_elem_r <= rd_ext[ilb_pkg::ELEM_W-1:0];
          if (!is_remove_r) begin
            state_r <= S_RESP;
          end else if (idx_p1 < cnt_ext) begin
            state_r <= S_SHIFT;
          end else begin
            count_r <= count_r - CW'(1);
            state_r <= S_RESP;
          end
        end
        S_SHIFT: begin
          idx_r <= idx_p1[CW-1:0];
          if (!(idx_p2 < cnt_ext)) begin
            count_r <= count_r - CW'(1);
            state_r <= S_RESP;
          end
        end
        S_RESP: begin
          if (res_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Result beat toward the output register.
  assign res_valid     = (state_r == S_RESP);
  assign res.element   = res_elem_r;
  assign res.count     = cnt_out[ilb_pkg::COUNT_W-1:0];
  assign res.empty_res = (count_r == '0);
  assign res.status    = res_status_r;

  // The count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("element count above capacity");

  // A write and a read of the same entry never meet in one cycle.
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_wr_en && mem_rd_en) |-> (mem_wr_addr != mem_rd_addr))
    else $error("same-entry read and write in one cycle");

  // An accepted append with room grows the count by one.
  a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && act == ilb_pkg::ACT_APPEND && !full) |=>
      (count_r == $past(count_r) + CW'(1)))
    else $error("append did not grow the count");

  // The move-down only runs over entries below the count.
  a_shift_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) |-> (idx_p1 < cnt_ext))
    else $error("move-down beyond the last element");

  // A full status is only reported at capacity.
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_status_r == ilb_pkg::ST_FULL) |-> full)
    else $error("full status below capacity");

endmodule

`default_nettype wire

@@ src/indexed_list_buffer.sv @@
// Indexed list buffer: an append or an error beat goes straight to the result state;
// a read first waits on the registered RAM read, and a remove also moves each later
// element down, one element per cycle through the single read and write port of the RAM.
// A new request is taken only once the sequencer has handed on the last result.
// A result waits in an output register while the next request is taken.
// Synchronous active-low reset empties the list; the RAM itself is not cleared.
`default_nettype none

module indexed_list_buffer #(
  parameter int DEPTH      = 256,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  ilb_in_if.sink    in_ch,
  ilb_out_if.source out_ch
);

  localparam int AW = $clog2(DEPTH);

  logic                  res_valid;
  ilb_pkg::res_t         res;
  logic                  res_ready;
  logic                  mem_wr_en;
  logic [AW-1:0]         mem_wr_addr;
  logic [DATA_WIDTH-1:0] mem_wr_data;
  logic                  mem_rd_en;
  logic [AW-1:0]         mem_rd_addr;
  logic [DATA_WIDTH-1:0] mem_rd_data;

  logic                  out_valid_r;
  ilb_pkg::res_t         out_res_r;

  ilb_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .res_valid   (res_valid),
    .res         (res),
    .res_ready   (res_ready),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  ilb_mem #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // Output register: loads when empty or when its beat leaves this cycle.
  assign res_ready = res_valid && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.element   = out_res_r.element;
  assign out_ch.count     = out_res_r.count;
  assign out_ch.empty_res = out_res_r.empty_res;
  assign out_ch.status    = out_res_r.status;

endmodule

`default_nettype wire
